// ----- src/c2d_pkg.sv -----
// ----------------------------------------------------------------------------
// c2d_pkg: shared types and constants for the 2D convolution engine
// Opcodes, register indexes, field widths and the control structs that pass
// between the tap sequencer, the multiply-accumulate unit and the top level.
// ----------------------------------------------------------------------------
package c2d_pkg;

   // Field widths fixed by the transaction format
   localparam int COORD_W  = 8;    // request row and column
   localparam int PIX_W    = 8;    // unsigned pixel
   localparam int COEF_W   = 8;    // signed coefficient
   localparam int SUM_W    = 22;   // convolution sum
   localparam int PROD_W   = PIX_W + 1 + COEF_W;
   localparam int DIM_W    = 9;    // image_height / image_width registers
   localparam int KSZ_W    = 3;    // kernel_size / center_offset registers
   localparam int LIM_W    = 10;   // saturated height or width, up to 511
   localparam int KDIM_W   = 4;    // saturated kernel side, up to 7
   localparam int TAP_W    = 11;   // signed window coordinate
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   // Request opcodes
   localparam logic [1:0] OP_WRITE_PIXEL = 2'd0;
   localparam logic [1:0] OP_WRITE_COEFF = 2'd1;
   localparam logic [1:0] OP_COMPUTE     = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_SIZE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_OFFSET = 3'd3;

   // Window geometry, already saturated into legal range
   typedef struct packed {
      logic [LIM_W-1:0]  h_lim;
      logic [LIM_W-1:0]  w_lim;
      logic [KDIM_W-1:0] k;
      logic [KSZ_W-1:0]  off;
   } geom_type;

   // Per-tap control travelling alongside the data path
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } tap_ctl_type;

endpackage

// ----- src/c2d_seq.sv -----
// ----------------------------------------------------------------------------
// c2d_seq: window tap sequencer
// Walks the k-by-k window one tap per cycle, clamps each tap coordinate to
// the image edge and issues frame and kernel store addresses.
// ----------------------------------------------------------------------------
module c2d_seq #(
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_KERNEL = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [c2d_pkg::COORD_W-1:0]   req_row,
   input  logic [c2d_pkg::COORD_W-1:0]   req_col,
   input  c2d_pkg::geom_type             geom,
   input  logic                          done,
   output logic                          busy,
   output logic [((MAX_HEIGHT*MAX_WIDTH > 1) ?
                  $clog2(MAX_HEIGHT*MAX_WIDTH) : 1)-1:0] frame_addr,
   output logic [((MAX_KERNEL*MAX_KERNEL > 1) ?
                  $clog2(MAX_KERNEL*MAX_KERNEL) : 1)-1:0] kern_addr,
   output c2d_pkg::tap_ctl_type          tap
);

   localparam int FA_W = (MAX_HEIGHT*MAX_WIDTH > 1) ? $clog2(MAX_HEIGHT*MAX_WIDTH) : 1;
   localparam int KA_W = (MAX_KERNEL*MAX_KERNEL > 1) ? $clog2(MAX_KERNEL*MAX_KERNEL) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT
   } state_type;

   state_type                         state_ff, state_in;
   logic [c2d_pkg::COORD_W-1:0]       row_ff, row_in;
   logic [c2d_pkg::COORD_W-1:0]       col_ff, col_in;
   c2d_pkg::geom_type                 geom_ff, geom_in;
   logic [c2d_pkg::KDIM_W-1:0]        i_ff, i_in;
   logic [c2d_pkg::KDIM_W-1:0]        j_ff, j_in;
   logic [FA_W-1:0]                   fa_ff, fa_in;
   logic [KA_W-1:0]                   ka_ff, ka_in;
   c2d_pkg::tap_ctl_type              tap_ff, tap_in;

   logic signed [c2d_pkg::TAP_W-1:0]  rc, cc;
   logic [c2d_pkg::LIM_W-1:0]         r_clamp, c_clamp;
   logic [c2d_pkg::KDIM_W-1:0]        k_last;
   logic                              last_tap;
   logic [31:0]                       fa_wide, ka_wide;

   // Clamp the current tap into the image
   always_comb begin
      rc = $signed(c2d_pkg::TAP_W'(row_ff)) - $signed(c2d_pkg::TAP_W'(geom_ff.off))
           + $signed(c2d_pkg::TAP_W'(i_ff));
      cc = $signed(c2d_pkg::TAP_W'(col_ff)) - $signed(c2d_pkg::TAP_W'(geom_ff.off))
           + $signed(c2d_pkg::TAP_W'(j_ff));
      if (rc < 0) begin
         r_clamp = '0;
      end else if (rc >= $signed(c2d_pkg::TAP_W'(geom_ff.h_lim))) begin
         r_clamp = geom_ff.h_lim - c2d_pkg::LIM_W'(1);
      end else begin
         r_clamp = rc[c2d_pkg::LIM_W-1:0];
      end
      if (cc < 0) begin
         c_clamp = '0;
      end else if (cc >= $signed(c2d_pkg::TAP_W'(geom_ff.w_lim))) begin
         c_clamp = geom_ff.w_lim - c2d_pkg::LIM_W'(1);
      end else begin
         c_clamp = cc[c2d_pkg::LIM_W-1:0];
      end
      fa_wide  = 32'(r_clamp) * 32'(MAX_WIDTH) + 32'(c_clamp);
      ka_wide  = 32'(i_ff) * 32'(MAX_KERNEL) + 32'(j_ff);
      k_last   = geom_ff.k - c2d_pkg::KDIM_W'(1);
      last_tap = (i_ff == k_last) && (j_ff == k_last);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      geom_in  = geom_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      fa_in    = fa_ff;
      ka_in    = ka_ff;
      tap_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               row_in   = req_row;
               col_in   = req_col;
               geom_in  = geom;
               i_in     = '0;
               j_in     = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            fa_in        = fa_wide[FA_W-1:0];
            ka_in        = ka_wide[KA_W-1:0];
            tap_in.valid = 1'b1;
            tap_in.first = (i_ff == '0) && (j_ff == '0);
            tap_in.last  = last_tap;
            if (last_tap) begin
               state_in = ST_WAIT;
            end else if (j_ff == k_last) begin
               j_in = '0;
               i_in = i_ff + c2d_pkg::KDIM_W'(1);
            end else begin
               j_in = j_ff + c2d_pkg::KDIM_W'(1);
            end
         end
         ST_WAIT: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
      row_ff  <= row_in;
      col_ff  <= col_in;
      geom_ff <= geom_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      fa_ff   <= fa_in;
      ka_ff   <= ka_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign frame_addr = fa_ff;
   assign kern_addr  = ka_ff;
   assign tap        = tap_ff;

endmodule

// ----- src/c2d_mac.sv -----
// ----------------------------------------------------------------------------
// c2d_mac: shared multiply-accumulate unit
// One pixel-by-coefficient product per cycle, registered, then summed into
// the accumulator; the last tap of a window raises the result strobe.
// ----------------------------------------------------------------------------
module c2d_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [c2d_pkg::PIX_W-1:0]          pix,
   input  logic signed [c2d_pkg::COEF_W-1:0]  coef,
   input  c2d_pkg::tap_ctl_type               ctl,
   output logic                               rsp_strobe,
   output logic signed [c2d_pkg::SUM_W-1:0]   rsp_conv_sum
);

   logic signed [c2d_pkg::PROD_W-1:0] prod_ff, prod_in;
   c2d_pkg::tap_ctl_type              ctl_ff;
   logic signed [c2d_pkg::SUM_W-1:0]  acc_ff, acc_in;
   logic signed [c2d_pkg::SUM_W-1:0]  sum_ff;
   logic                              strobe_ff;

   always_comb begin
      prod_in = $signed({1'b0, pix}) * coef;
      acc_in  = (ctl_ff.first ? c2d_pkg::SUM_W'(0) : acc_ff)
                + c2d_pkg::SUM_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         ctl_ff    <= ctl;
         strobe_ff <= ctl_ff.valid && ctl_ff.last;
      end
      prod_ff <= prod_in;
      if (ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (ctl_ff.valid && ctl_ff.last) begin
         sum_ff <= acc_in;
      end
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_conv_sum = sum_ff;

endmodule

// ----- src/conv2d_clamp_edge.sv -----
// ----------------------------------------------------------------------------
// conv2d_clamp_edge: integer 2D convolution with clamp-to-edge borders
// Frame and kernel stores, configuration registers, a tap sequencer and one
// shared multiply-accumulate unit that sums a k-by-k window per request.
// ----------------------------------------------------------------------------
//
// Channel   Ports                                         Handshake
// request   req_opcode/row/col/pixel_value/coeff_value    start & !busy
// response  rsp_conv_sum                                  rsp_strobe, 1 cycle
// config    csr_index, csr_data                           csr_valid & csr_ready
//
// A pixel or coefficient write leaves busy low, and the next transaction may
// follow at once. A compute request holds busy until its result; it makes one
// multiply-accumulate per window tap, paced by the single frame store read
// port. The result strobe follows the last tap through the sequencer tap,
// store read and MAC control registers. The receiver cannot stall; each
// result is shown for one cycle only.
// Reset is synchronous; store contents are undefined until written and are
// not cleared. Configuration is always ready; write it only while idle.
// ----------------------------------------------------------------------------
module conv2d_clamp_edge #(
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_KERNEL = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_opcode,
   input  logic [c2d_pkg::COORD_W-1:0]          req_row,
   input  logic [c2d_pkg::COORD_W-1:0]          req_col,
   input  logic [c2d_pkg::PIX_W-1:0]            req_pixel_value,
   input  logic signed [c2d_pkg::COEF_W-1:0]    req_coeff_value,
   output logic                                 rsp_strobe,
   output logic signed [c2d_pkg::SUM_W-1:0]     rsp_conv_sum,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [c2d_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [c2d_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int FA_W   = (MAX_HEIGHT*MAX_WIDTH > 1) ? $clog2(MAX_HEIGHT*MAX_WIDTH) : 1;
   localparam int KA_W   = (MAX_KERNEL*MAX_KERNEL > 1) ? $clog2(MAX_KERNEL*MAX_KERNEL) : 1;
   localparam int FDEPTH = MAX_HEIGHT * MAX_WIDTH;
   localparam int KDEPTH = MAX_KERNEL * MAX_KERNEL;

   // Configuration registers
   logic [c2d_pkg::DIM_W-1:0]  height_ff, width_ff;
   logic [c2d_pkg::KSZ_W-1:0]  ksize_ff, offset_ff;
   c2d_pkg::geom_type          geom;

   // Transaction decode
   logic                       accept, go, pix_we, coef_we;
   logic [31:0]                pix_wa_wide, coef_wa_wide;

   // Stores and their registered read ports
   logic [c2d_pkg::PIX_W-1:0]  frame_mem [FDEPTH];
   logic [c2d_pkg::COEF_W-1:0] kern_mem  [KDEPTH];
   logic [c2d_pkg::PIX_W-1:0]  pix_rd_ff;
   logic [c2d_pkg::COEF_W-1:0] coef_rd_ff;
   c2d_pkg::tap_ctl_type       ctl_rd_ff;

   logic [FA_W-1:0]            frame_addr;
   logic [KA_W-1:0]            kern_addr;
   c2d_pkg::tap_ctl_type       tap;
   logic                       seq_busy;

   assign csr_ready = 1'b1;
   assign busy      = seq_busy;
   assign accept    = start && !seq_busy;
   assign go        = accept && (req_opcode == c2d_pkg::OP_COMPUTE);

   // Out-of-range writes drop silently
   always_comb begin
      pix_wa_wide  = 32'(req_row) * 32'(MAX_WIDTH) + 32'(req_col);
      coef_wa_wide = 32'(req_row) * 32'(MAX_KERNEL) + 32'(req_col);
      pix_we  = accept && (req_opcode == c2d_pkg::OP_WRITE_PIXEL)
                && (32'(req_row) < 32'(MAX_HEIGHT)) && (32'(req_col) < 32'(MAX_WIDTH));
      coef_we = accept && (req_opcode == c2d_pkg::OP_WRITE_COEFF)
                && (32'(req_row) < 32'(MAX_KERNEL)) && (32'(req_col) < 32'(MAX_KERNEL));
   end

   // Saturate the geometry registers into the legal range of the stores
   always_comb begin
      if (height_ff == '0) begin
         geom.h_lim = c2d_pkg::LIM_W'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         geom.h_lim = c2d_pkg::LIM_W'(MAX_HEIGHT);
      end else begin
         geom.h_lim = c2d_pkg::LIM_W'(height_ff);
      end
      if (width_ff == '0) begin
         geom.w_lim = c2d_pkg::LIM_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         geom.w_lim = c2d_pkg::LIM_W'(MAX_WIDTH);
      end else begin
         geom.w_lim = c2d_pkg::LIM_W'(width_ff);
      end
      if (ksize_ff == '0) begin
         geom.k = c2d_pkg::KDIM_W'(1);
      end else if (32'(ksize_ff) > 32'(MAX_KERNEL)) begin
         geom.k = c2d_pkg::KDIM_W'(MAX_KERNEL);
      end else begin
         geom.k = c2d_pkg::KDIM_W'(ksize_ff);
      end
      geom.off = offset_ff;
   end

   // Configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= c2d_pkg::DIM_W'(1);
         width_ff  <= c2d_pkg::DIM_W'(1);
         ksize_ff  <= c2d_pkg::KSZ_W'(3);
         offset_ff <= c2d_pkg::KSZ_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            c2d_pkg::CSR_IMAGE_HEIGHT:  height_ff <= csr_data;
            c2d_pkg::CSR_IMAGE_WIDTH:   width_ff  <= csr_data;
            c2d_pkg::CSR_KERNEL_SIZE:   ksize_ff  <= csr_data[c2d_pkg::KSZ_W-1:0];
            c2d_pkg::CSR_CENTER_OFFSET: offset_ff <= csr_data[c2d_pkg::KSZ_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Frame store: one write port for pixel loads, one registered read port
   always_ff @(posedge clock) begin
      if (pix_we) begin
         frame_mem[pix_wa_wide[FA_W-1:0]] <= req_pixel_value;
      end
      pix_rd_ff <= frame_mem[frame_addr];
   end

   // Kernel store: same arrangement
   always_ff @(posedge clock) begin
      if (coef_we) begin
         kern_mem[coef_wa_wide[KA_W-1:0]] <= req_coeff_value;
      end
      coef_rd_ff <= kern_mem[kern_addr];
   end

   // Delay tap control to line up with the store read data
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_rd_ff <= '0;
      end else begin
         ctl_rd_ff <= tap;
      end
   end

   c2d_seq #(
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_KERNEL (MAX_KERNEL)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .go         (go),
      .req_row    (req_row),
      .req_col    (req_col),
      .geom       (geom),
      .done       (rsp_strobe),
      .busy       (seq_busy),
      .frame_addr (frame_addr),
      .kern_addr  (kern_addr),
      .tap        (tap)
   );

   c2d_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .pix          (pix_rd_ff),
      .coef         ($signed(coef_rd_ff)),
      .ctl          (ctl_rd_ff),
      .rsp_strobe   (rsp_strobe),
      .rsp_conv_sum (rsp_conv_sum)
   );

`ifndef SYNTH
   // A result only ever ends a compute in progress
   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a compute transaction");

   // The result strobe is a single pulse: never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // An accepted compute must raise busy
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode == c2d_pkg::OP_COMPUTE)) |=> busy)
      else $error("compute accepted without going busy");

   // Window taps issue only while a compute is in progress
   a_no_tap_when_idle: assert property (@(posedge clock) disable iff (reset)
      tap.valid |-> busy)
      else $error("window tap issued while idle");
`endif

endmodule
